// ----- rtl/core/salc_pkg.sv -----
// Shared types, constants and codes of the set-associative LRU cache model.
`timescale 1ns / 1ps
`default_nettype none
package salc_pkg;

  // Sets in the store: a power of two, 2 ** SET_LG, at most 65536.
  localparam int SET_LG    = 8;
  localparam int SET_COUNT = 1 << SET_LG;
  localparam int SET_IW    = (SET_COUNT > 1) ? SET_LG : 1;

  // Lines per set, 1 to 32.
  localparam int WAY_COUNT = 8;
  localparam int WAY_LG    = $clog2(WAY_COUNT);
  localparam int WAY_PAD   = 1 << WAY_LG;
  localparam int WAY_IW    = (WAY_COUNT > 1) ? WAY_LG : 1;
  localparam int WCNT_W    = 6;

  localparam int ADDR_W  = 32;
  localparam int TAG_W   = 32;
  localparam int STAMP_W = 32;
  localparam int CNT_W   = 32;

  // Configuration port.
  localparam int CFG_AW = 2;
  localparam int CFG_DW = 5;
  localparam logic [CFG_AW-1:0] CFG_SET_BITS   = 2'd0;
  localparam logic [CFG_AW-1:0] CFG_BLOCK_BITS = 2'd1;
  localparam logic [CFG_AW-1:0] CFG_WAYS       = 2'd2;

  typedef enum logic [1:0] {
    OUT_HIT   = 2'd0,
    OUT_FILL  = 2'd1,
    OUT_EVICT = 2'd2
  } outcome_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_LOOK,
    S_AGAIN
  } state_t;

  typedef struct packed {
    logic               valid;
    logic [TAG_W-1:0]   tag;
    logic [STAMP_W-1:0] stamp;
  } line_t;

  typedef line_t [WAY_COUNT-1:0] row_t;

  localparam int ROW_W = $bits(row_t);

endpackage
`default_nettype wire

// ----- rtl/core/salc_in_if.sv -----
// Input channel of the cache model: one address and opcode per transaction.
`timescale 1ns / 1ps
`default_nettype none
interface salc_in_if;
  import salc_pkg::*;

  logic              valid;
  logic              ready;
  logic [ADDR_W-1:0] address;
  logic              opcode;

  modport source (output valid, output address, output opcode, input ready);
  modport sink   (input valid, input address, input opcode, output ready);
endinterface
`default_nettype wire

// ----- rtl/core/salc_out_if.sv -----
// Result channel of the cache model: outcome and running totals per access.
`timescale 1ns / 1ps
`default_nettype none
interface salc_out_if;
  import salc_pkg::*;

  logic             valid;
  logic             ready;
  logic [1:0]       outcome;
  logic [CNT_W-1:0] hit_total;
  logic [CNT_W-1:0] miss_total;
  logic [CNT_W-1:0] eviction_total;
  logic             is_last;

  modport source (output valid, output outcome, output hit_total, output miss_total,
                  output eviction_total, output is_last, input ready);
  modport sink   (input valid, input outcome, input hit_total, input miss_total,
                  input eviction_total, input is_last, output ready);
endinterface
`default_nettype wire

// ----- rtl/core/salc_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module salc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

// ----- rtl/core/set_assoc_lru_cache_model.sv -----
// Top level: tag-only set-associative cache with LRU replacement and hit/miss totals.
//
//   channel   direction  handshake          payload
//   in_ch     sink       valid/ready        address[31:0], opcode
//   out_ch    source     valid/ready        outcome[1:0], hit/miss/eviction totals, is_last
//   cfg_*     sink       cfg_we (no wait)   cfg_addr[1:0] register index, cfg_data[4:0]
//
// A load/store reads the set from the row RAM, then looks up, picks the way and writes
// the row back. A modify then makes a second access on the row just written, held in a
// register, and writes it back again.
// Reset clears the per-row valid bits at once; a row never written reads as all lines
// invalid, so no clearing pass runs. The block stalls in either lookup step while the
// output register holds a result that is not taken; a new transaction is taken only
// in the idle state, which is reached while a result may still wait in the output.
`timescale 1ns / 1ps
`default_nettype none
module set_assoc_lru_cache_model (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  salc_in_if.sink                        in_ch,
  salc_out_if.source                     out_ch,
  input  wire logic                      cfg_we,
  input  wire logic [salc_pkg::CFG_AW-1:0] cfg_addr,
  input  wire logic [salc_pkg::CFG_DW-1:0] cfg_data
);
  import salc_pkg::*;

  // Configuration registers.
  logic [3:0] set_bits_r;
  logic [4:0] block_bits_r;
  logic [3:0] ways_r;

  // Control and per-transaction state.
  state_t              state_r, state_nxt;
  logic                op_r;
  logic [TAG_W-1:0]    tag_r;
  logic [SET_IW-1:0]   idx_r;
  logic [SET_COUNT-1:0] rowv_r;
  logic                rowv_q_r;
  row_t                row_r;

  logic [STAMP_W-1:0] clock_r, clock_nxt;
  logic [CNT_W-1:0]   hit_r, miss_r, evict_r;

  // Output register.
  logic             out_valid_r;
  outcome_t         out_outcome_r;
  logic [CNT_W-1:0] out_hit_r, out_miss_r, out_evict_r;
  logic             out_last_r;

  // Handshake and step control.
  logic accept, out_free, go, ram_re;

  // Address split.
  logic [5:0]        shift_sum;
  logic [TAG_W-1:0]  tag_nxt;
  logic [ADDR_W-1:0] shifted;
  logic [15:0]       idx_mask, idx_full;
  logic [SET_IW-1:0] idx_nxt;

  // Lookup.
  row_t             ram_rdata, src_row, row_new;
  logic [WCNT_W-1:0] ways_eff;
  logic [WAY_COUNT-1:0] hit_vec, free_vec, use_vec;
  logic             hit_any, free_any;
  logic [WAY_IW-1:0] hit_way, free_way, victim, pick_way;
  outcome_t         outcome;

  logic               node_act   [2*WAY_PAD];
  logic [STAMP_W-1:0] node_stamp [2*WAY_PAD];
  logic [WAY_IW-1:0]  node_way   [2*WAY_PAD];

  // ---------------------------------------------------------------------------
  // Configuration writes
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      set_bits_r   <= 4'd0;
      block_bits_r <= 5'd0;
      ways_r       <= 4'd1;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_SET_BITS:   set_bits_r   <= cfg_data[3:0];
        CFG_BLOCK_BITS: block_bits_r <= cfg_data;
        CFG_WAYS:       ways_r       <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Address split: tag drops set and offset bits, set index is masked to set_bits
  // and folded onto the sets that exist.
  // ---------------------------------------------------------------------------
  always_comb begin
    shift_sum = {2'b00, set_bits_r} + {1'b0, block_bits_r};
    tag_nxt   = (shift_sum >= 6'd32) ? '0 : (in_ch.address >> shift_sum[4:0]);
    shifted   = in_ch.address >> block_bits_r;
    idx_mask  = 16'((17'd1 << set_bits_r) - 17'd1);
    idx_full  = shifted[15:0] & idx_mask;
    idx_nxt   = (SET_COUNT > 1) ? SET_IW'(idx_full) : '0;
  end

  // ---------------------------------------------------------------------------
  // Row RAM: one row holds every way of a set.
  // ---------------------------------------------------------------------------
  salc_ram #(
    .WIDTH (ROW_W),
    .DEPTH (SET_COUNT)
  ) u_row_ram (
    .clk   (clk),
    .we    (go),
    .waddr (idx_r),
    .wdata (row_new),
    .re    (ram_re),
    .raddr (idx_nxt),
    .rdata (ram_rdata)
  );

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (accept) state_nxt = S_LOOK;
      S_LOOK:  if (go)     state_nxt = op_r ? S_AGAIN : S_IDLE;
      S_AGAIN: if (go)     state_nxt = S_IDLE;
      default:             state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_free    = !out_valid_r || out_ch.ready;
    in_ch.ready = (state_r == S_IDLE);
    accept      = in_ch.valid && in_ch.ready;
    ram_re      = accept;
    go          = (state_r != S_IDLE) && out_free;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Latch the transaction and the row-valid bit of its set.
  always_ff @(posedge clk) begin
    if (accept) begin
      op_r     <= in_ch.opcode;
      tag_r    <= tag_nxt;
      idx_r    <= idx_nxt;
      rowv_q_r <= rowv_r[idx_nxt];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rowv_r <= '0;
    end else if (go) begin
      rowv_r[idx_r] <= 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // Lookup: hit search, first free way, LRU victim through a compare tree.
  // The second access of a modify works on the row just written (forwarded).
  // ---------------------------------------------------------------------------
  always_comb begin
    if (ways_r == 4'd0) begin
      ways_eff = WCNT_W'(1);
    end else if ({2'b00, ways_r} > WCNT_W'(WAY_COUNT)) begin
      ways_eff = WCNT_W'(WAY_COUNT);
    end else begin
      ways_eff = {2'b00, ways_r};
    end
  end

  always_comb begin
    if (state_r == S_LOOK) begin
      src_row = rowv_q_r ? ram_rdata : '0;
    end else begin
      src_row = row_r;
    end
  end

  always_comb begin
    for (int w = 0; w < WAY_COUNT; w++) begin
      use_vec[w]  = WCNT_W'(w) < ways_eff;
      hit_vec[w]  = use_vec[w] && src_row[w].valid && (src_row[w].tag == tag_r);
      free_vec[w] = use_vec[w] && !src_row[w].valid;
    end
    hit_any  = |hit_vec;
    free_any = |free_vec;

    hit_way  = '0;
    free_way = '0;
    for (int w = WAY_COUNT - 1; w >= 0; w--) begin
      if (hit_vec[w])  hit_way  = WAY_IW'(w);
      if (free_vec[w]) free_way = WAY_IW'(w);
    end
  end

  // Min-stamp tree; the left side wins a tie, so the lowest way is chosen.
  always_comb begin
    for (int n = 0; n < 2 * WAY_PAD; n++) begin
      node_act[n]   = 1'b0;
      node_stamp[n] = '0;
      node_way[n]   = '0;
    end
    for (int w = 0; w < WAY_PAD; w++) begin
      if (w < WAY_COUNT) begin
        node_act[WAY_PAD + w]   = use_vec[w];
        node_stamp[WAY_PAD + w] = src_row[w].stamp;
        node_way[WAY_PAD + w]   = WAY_IW'(w);
      end
    end
    for (int n = WAY_PAD - 1; n >= 1; n--) begin
      if (node_act[2*n+1] && (!node_act[2*n] || (node_stamp[2*n+1] < node_stamp[2*n]))) begin
        node_act[n]   = 1'b1;
        node_stamp[n] = node_stamp[2*n+1];
        node_way[n]   = node_way[2*n+1];
      end else begin
        node_act[n]   = node_act[2*n];
        node_stamp[n] = node_stamp[2*n];
        node_way[n]   = node_way[2*n];
      end
    end
    victim = node_way[1];
  end

  always_comb begin
    clock_nxt = (clock_r == '1) ? clock_r : clock_r + STAMP_W'(1);
    priority if (hit_any) begin
      outcome  = OUT_HIT;
      pick_way = hit_way;
    end else if (free_any) begin
      outcome  = OUT_FILL;
      pick_way = free_way;
    end else begin
      outcome  = OUT_EVICT;
      pick_way = victim;
    end
    row_new                 = src_row;
    row_new[pick_way].valid = 1'b1;
    row_new[pick_way].tag   = tag_r;
    row_new[pick_way].stamp = clock_nxt;
  end

  // Hold the written row for the second access of a modify.
  always_ff @(posedge clk) begin
    if (go) begin
      row_r <= row_new;
    end
  end

  // Use clock and saturating totals.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clock_r <= '0;
      hit_r   <= '0;
      miss_r  <= '0;
      evict_r <= '0;
    end else if (go) begin
      clock_r <= clock_nxt;
      if (outcome == OUT_HIT && hit_r != '1) begin
        hit_r <= hit_r + CNT_W'(1);
      end
      if (outcome != OUT_HIT && miss_r != '1) begin
        miss_r <= miss_r + CNT_W'(1);
      end
      if (outcome == OUT_EVICT && evict_r != '1) begin
        evict_r <= evict_r + CNT_W'(1);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Output register: load on each access, drop once taken.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (go) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      out_outcome_r <= outcome;
      out_hit_r     <= (outcome == OUT_HIT && hit_r != '1) ? hit_r + CNT_W'(1) : hit_r;
      out_miss_r    <= (outcome != OUT_HIT && miss_r != '1) ? miss_r + CNT_W'(1) : miss_r;
      out_evict_r   <= (outcome == OUT_EVICT && evict_r != '1) ? evict_r + CNT_W'(1)
                                                               : evict_r;
      out_last_r    <= (state_r == S_AGAIN) || !op_r;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.outcome        = out_outcome_r;
  assign out_ch.hit_total      = out_hit_r;
  assign out_ch.miss_total     = out_miss_r;
  assign out_ch.eviction_total = out_evict_r;
  assign out_ch.is_last        = out_last_r;

`ifndef SYNTHESIS
  // The second access of a modify always finds the line the first one touched.
  a_again_hits: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_AGAIN && go) |-> hit_any)
    else $error("second access of modify missed");

  // An accepted transaction always moves on to the lookup step.
  a_accept_look: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (state_r == S_LOOK))
    else $error("accepted transaction did not enter lookup");

  // Every step that writes the row also presents a result.
  a_go_out: assert property (@(posedge clk) disable iff (!rst_n)
    go |=> out_valid_r)
    else $error("access finished without a result");

  // A hit below saturation advances the hit total by one.
  a_hit_count: assert property (@(posedge clk) disable iff (!rst_n)
    (go && hit_any && hit_r != '1) |=> (hit_r == $past(hit_r) + CNT_W'(1)))
    else $error("hit total did not advance");

  // A finished result is never overwritten before it is taken.
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ch.ready) |-> !go)
    else $error("result overwritten while stalled");
`endif

endmodule
`default_nettype wire
